// ===== rtl/pfe_pkg.sv =====
// Shared types and constants of the postfix range evaluator.
// Used by every module of the block but pfe_ram; depends on nothing.
`default_nettype none
package pfe_pkg;
    localparam int PROGRAM_DEPTH = 64;
    localparam int STACK_DEPTH   = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int DIV_STEPS     = 32;

    localparam int PC_W  = $clog2(PROGRAM_DEPTH);
    localparam int CNT_W = $clog2(PROGRAM_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int QA_W  = $clog2(QUEUE_DEPTH);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DC_W  = $clog2(DIV_STEPS);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MALFORMED = 3'd1;
    localparam logic [2:0] ST_LITERAL   = 3'd2;
    localparam logic [2:0] ST_LONG      = 3'd3;
    localparam logic [2:0] ST_STACK     = 3'd4;

    localparam logic CFG_BOUND_A = 1'b0;
    localparam logic CFG_BOUND_B = 1'b1;

    typedef enum logic [2:0] {
        TK_NUM = 3'd0,
        TK_VAR = 3'd1,
        TK_ADD = 3'd2,
        TK_SUB = 3'd3,
        TK_MUL = 3'd4,
        TK_DIV = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
    } t_token;

    // One queue entry: an optional closed literal, then an optional symbol.
    typedef struct packed {
        logic        lit_en;
        logic        lit_ovf;
        logic [31:0] lit_val;
        logic        op_en;
        t_kind       op_kind;
        logic        last;
    } t_entry;
endpackage
`default_nettype wire

// ===== rtl/pfe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/pfe_front.sv =====
// Front end: takes characters, builds decimal literals and classifies symbols.
// Depends on pfe_pkg; feeds pfe_queue.
`default_nettype none
module pfe_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_char_code,
    input  wire logic           i_last_char,
    input  wire logic           i_full,
    output logic                o_push,
    output pfe_pkg::t_entry     o_entry
);
    logic [31:0] r_accum, n_accum;
    logic        r_active, n_active;
    logic        take, digit;
    logic [35:0] next_val;
    logic [31:0] acc_eff;
    logic        act_eff;

    always_comb begin
        take     = i_valid && !i_full;
        digit    = (i_char_code >= pfe_pkg::CH_ZERO) && (i_char_code <= pfe_pkg::CH_NINE);
        next_val = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1)
                 + 36'(i_char_code - pfe_pkg::CH_ZERO);
        acc_eff  = r_accum;
        act_eff  = r_active;
        if (digit) begin
            // An overflowing literal saturates just above the signed range.
            acc_eff = (next_val > 36'(pfe_pkg::S32_MAX)) ? pfe_pkg::S32_MIN : next_val[31:0];
            act_eff = 1'b1;
        end
        o_entry.lit_en  = act_eff;
        o_entry.lit_ovf = acc_eff[31];
        o_entry.lit_val = acc_eff;
        o_entry.last    = i_last_char;
        o_entry.op_en   = 1'b1;
        o_entry.op_kind = pfe_pkg::TK_ADD;
        case (i_char_code)
            pfe_pkg::CH_PLUS:  o_entry.op_kind = pfe_pkg::TK_ADD;
            pfe_pkg::CH_MINUS: o_entry.op_kind = pfe_pkg::TK_SUB;
            pfe_pkg::CH_STAR:  o_entry.op_kind = pfe_pkg::TK_MUL;
            pfe_pkg::CH_SLASH: o_entry.op_kind = pfe_pkg::TK_DIV;
            pfe_pkg::CH_X:     o_entry.op_kind = pfe_pkg::TK_VAR;
            default:           o_entry.op_en   = 1'b0;
        endcase
        o_push   = take && (!digit || i_last_char);
        n_accum  = r_accum;
        n_active = r_active;
        if (take) begin
            if (o_push) begin
                n_accum  = '0;
                n_active = 1'b0;
            end else begin
                n_accum  = acc_eff;
                n_active = act_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum  <= '0;
            r_active <= 1'b0;
        end else begin
            r_accum  <= n_accum;
            r_active <= n_active;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pfe_queue.sv =====
// Short FIFO of classified entries between the front end and the back end.
// Depends on pfe_pkg.
`default_nettype none
module pfe_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pfe_pkg::t_entry i_entry,
    output logic                o_full,
    output logic                o_valid,
    output pfe_pkg::t_entry     o_entry,
    input  wire logic           i_pop
);
    pfe_pkg::t_entry                r_mem [pfe_pkg::QUEUE_DEPTH];
    logic [pfe_pkg::QA_W-1:0]       r_wp, r_rp;
    logic [pfe_pkg::QC_W-1:0]       r_cnt;
    logic                           do_pop;

    assign o_full  = (r_cnt == pfe_pkg::QC_W'(pfe_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + pfe_pkg::QA_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + pfe_pkg::QA_W'(1);
            end
            r_cnt <= r_cnt + pfe_pkg::QC_W'(i_push) - pfe_pkg::QC_W'(do_pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pfe_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pfe_pkg.
`default_nettype none
module pfe_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    logic [31:0]              r_rem, r_q, r_den;
    logic                     r_neg, r_busy, r_done;
    logic [pfe_pkg::DC_W-1:0] r_cnt;
    logic [32:0]              trial;
    logic [31:0]              shifted;

    assign shifted = {r_rem[30:0], r_q[31]};
    assign trial   = {1'b0, shifted} - {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_neg ? (32'd0 - r_q) : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + pfe_pkg::DC_W'(1);
                if (r_cnt == pfe_pkg::DC_W'(pfe_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num[31] ? (32'd0 - i_num) : i_num;
            r_den <= i_den[31] ? (32'd0 - i_den) : i_den;
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            if (!trial[32]) begin
                r_rem <= trial[31:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pfe_back.sv =====
// Back end: stores tokens, checks stack shape, then evaluates every x of the
// range on a token RAM and an operand stack RAM. Depends on pfe_pkg, pfe_ram, pfe_div.
`default_nettype none
module pfe_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire pfe_pkg::t_entry i_q_entry,
    output logic                o_q_pop,
    input  wire logic [31:0]    i_bound_a,
    input  wire logic [31:0]    i_bound_b,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [31:0]         o_min_result,
    output logic [31:0]         o_max_result,
    output logic [2:0]          o_status
);
    typedef enum logic [7:0] {
        S_LOAD   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_FETCH  = 8'b0000_0100,
        S_DECODE = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_UPDATE = 8'b0010_0000,
        S_NEXT   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state                    r_state, n_state;
    logic [pfe_pkg::CNT_W-1:0] r_count, n_count;
    logic [2:0]                r_load_err, n_load_err, r_shape_err, n_shape_err;
    logic [pfe_pkg::SP_W-1:0]  r_depth, n_depth, r_sp, n_sp;
    logic                      r_lit_done, n_lit_done;
    logic [31:0]               r_x, n_x, r_hi, n_hi, r_top, n_top;
    logic [31:0]               r_min, n_min, r_max, n_max;
    logic [2:0]                r_status, n_status;
    logic [pfe_pkg::PC_W-1:0]  r_pc, n_pc;

    logic                      tok_we, st_we, div_start, div_done, do_tok, adv, is_last;
    pfe_pkg::t_token           tok_w, tok_r;
    logic [$bits(pfe_pkg::t_token)-1:0] tok_rdata;
    logic [31:0]               st_wdata, st_rdata, div_quot, lo, hi;
    logic [pfe_pkg::SP_W-1:0]  sp_m1, sp_m2;
    logic [2:0]                chk;

    assign sp_m1   = r_sp - pfe_pkg::SP_W'(1);
    assign sp_m2   = r_sp - pfe_pkg::SP_W'(2);
    assign tok_r   = pfe_pkg::t_token'(tok_rdata);
    assign is_last = (pfe_pkg::CNT_W'(r_pc) + pfe_pkg::CNT_W'(1)) == r_count;

    pfe_ram #(.WIDTH($bits(pfe_pkg::t_token)), .DEPTH(pfe_pkg::PROGRAM_DEPTH)) u_tok_ram (
        .i_clk  (i_clk),
        .i_we   (tok_we),
        .i_waddr(r_count[pfe_pkg::PC_W-1:0]),
        .i_wdata(tok_w),
        .i_raddr(r_pc),
        .o_rdata(tok_rdata)
    );

    pfe_ram #(.WIDTH(32), .DEPTH(pfe_pkg::STACK_DEPTH)) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(sp_m1[pfe_pkg::SA_W-1:0]),
        .i_wdata(st_wdata),
        .i_raddr(sp_m2[pfe_pkg::SA_W-1:0]),
        .o_rdata(st_rdata)
    );

    pfe_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (st_rdata),
        .i_den  (r_top),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    always_comb begin
        n_state = r_state;     n_count = r_count;       n_load_err = r_load_err;
        n_shape_err = r_shape_err; n_depth = r_depth;   n_lit_done = r_lit_done;
        n_x = r_x;  n_hi = r_hi; n_top = r_top; n_min = r_min; n_max = r_max;
        n_status = r_status;   n_pc = r_pc;             n_sp = r_sp;
        o_q_pop = 1'b0; tok_we = 1'b0; st_we = 1'b0; div_start = 1'b0;
        do_tok = 1'b0; adv = 1'b0;
        tok_w.kind = pfe_pkg::TK_NUM; tok_w.value = i_q_entry.lit_val;
        st_wdata = r_top;
        lo = ($signed(i_bound_a) < $signed(i_bound_b)) ? i_bound_a : i_bound_b;
        hi = ($signed(i_bound_a) < $signed(i_bound_b)) ? i_bound_b : i_bound_a;
        chk = (r_load_err != pfe_pkg::ST_OK) ? r_load_err
            : (r_count == '0) ? pfe_pkg::ST_MALFORMED : r_shape_err;

        unique case (r_state)
            S_LOAD: begin
                if (i_q_valid) begin
                    if (i_q_entry.lit_en && !r_lit_done) begin
                        n_lit_done = 1'b1;
                        if (i_q_entry.lit_ovf) begin
                            if (r_load_err == pfe_pkg::ST_OK) begin
                                n_load_err = pfe_pkg::ST_LITERAL;
                            end
                        end else begin
                            do_tok = 1'b1;
                        end
                    end else begin
                        o_q_pop    = 1'b1;
                        n_lit_done = 1'b0;
                        do_tok     = i_q_entry.op_en;
                        tok_w.kind = i_q_entry.op_kind;
                        tok_w.value = '0;
                        if (i_q_entry.last) begin
                            n_state = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK: begin
                n_status = chk;
                n_min = pfe_pkg::S32_MAX;
                n_max = pfe_pkg::S32_MIN;
                n_x = lo; n_hi = hi; n_pc = '0; n_sp = '0;
                n_state = (chk != pfe_pkg::ST_OK) ? S_OUT : S_FETCH;
            end
            S_FETCH: begin
                n_state = S_DECODE;
            end
            S_DECODE: begin
                case (tok_r.kind)
                    pfe_pkg::TK_NUM, pfe_pkg::TK_VAR: begin
                        st_we = (r_sp != '0);
                        n_top = (tok_r.kind == pfe_pkg::TK_VAR) ? r_x : tok_r.value;
                        n_sp  = r_sp + pfe_pkg::SP_W'(1);
                        adv   = 1'b1;
                    end
                    pfe_pkg::TK_ADD: begin
                        n_top = st_rdata + r_top; n_sp = sp_m1; adv = 1'b1;
                    end
                    pfe_pkg::TK_SUB: begin
                        n_top = st_rdata - r_top; n_sp = sp_m1; adv = 1'b1;
                    end
                    pfe_pkg::TK_MUL: begin
                        n_top = st_rdata * r_top; n_sp = sp_m1; adv = 1'b1;
                    end
                    default: begin
                        // Division by zero abandons this x without touching min or max.
                        if (r_top == '0) begin
                            n_state = S_NEXT;
                        end else begin
                            div_start = 1'b1;
                            n_state = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_top = div_quot; n_sp = sp_m1; adv = 1'b1;
                end
            end
            S_UPDATE: begin
                if ($signed(r_top) < $signed(r_min)) n_min = r_top;
                if ($signed(r_top) > $signed(r_max)) n_max = r_top;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (r_x == r_hi) begin
                    n_state = S_OUT;
                end else begin
                    n_x = r_x + 32'd1; n_pc = '0; n_sp = '0;
                    n_state = S_FETCH;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_count = '0; n_load_err = pfe_pkg::ST_OK;
                    n_shape_err = pfe_pkg::ST_OK; n_depth = '0; n_lit_done = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase

        if (adv) begin
            if (is_last) begin
                n_state = S_UPDATE;
            end else begin
                n_pc = r_pc + pfe_pkg::PC_W'(1);
                n_state = S_FETCH;
            end
        end

        if (do_tok) begin
            if (r_count >= pfe_pkg::CNT_W'(pfe_pkg::PROGRAM_DEPTH)) begin
                if (n_load_err == pfe_pkg::ST_OK) begin
                    n_load_err = pfe_pkg::ST_LONG;
                end
            end else begin
                tok_we  = 1'b1;
                n_count = r_count + pfe_pkg::CNT_W'(1);
                if (r_shape_err == pfe_pkg::ST_OK) begin
                    if (tok_w.kind == pfe_pkg::TK_NUM || tok_w.kind == pfe_pkg::TK_VAR) begin
                        if (r_depth >= pfe_pkg::SP_W'(pfe_pkg::STACK_DEPTH)) begin
                            n_shape_err = pfe_pkg::ST_STACK;
                        end else begin
                            n_depth = r_depth + pfe_pkg::SP_W'(1);
                        end
                    end else if (r_depth < pfe_pkg::SP_W'(2)) begin
                        n_shape_err = pfe_pkg::ST_MALFORMED;
                    end else begin
                        n_depth = r_depth - pfe_pkg::SP_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_load_err  <= pfe_pkg::ST_OK;
            r_shape_err <= pfe_pkg::ST_OK;
            r_depth     <= '0;
            r_lit_done  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_load_err  <= n_load_err;
            r_shape_err <= n_shape_err;
            r_depth     <= n_depth;
            r_lit_done  <= n_lit_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_hi <= n_hi; r_top <= n_top; r_min <= n_min; r_max <= n_max;
        r_status <= n_status; r_pc <= n_pc; r_sp <= n_sp;
    end

    assign o_valid      = (r_state == S_OUT);
    assign o_min_result = r_min;
    assign o_max_result = r_max;
    assign o_status     = r_status;
endmodule
`default_nettype wire

// ===== rtl/postfix_expression_range_min_max.sv =====
// Top level of the postfix range evaluator: bound registers, front end, queue, back end.
// Depends on pfe_pkg, pfe_front, pfe_queue, pfe_back.
`default_nettype none
// Characters are taken one per cycle while the four-beat entry queue has room.
// On the last character the back end evaluates the stored program for every x
// between the two bounds: each token passes the fetch and decode states (token
// RAM and stack RAM reads), each division also waits for the bit-serial divider,
// and each x then passes the update and next states; an expression with an error
// status goes from the check state straight to the result beat. The result beat
// then waits until taken. Bounds may be written only while the block is idle.
module postfix_expression_range_min_max (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_last_char,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_min_result,
    output logic [31:0]      o_max_result,
    output logic [2:0]       o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    logic [31:0]     r_bound_a, r_bound_b;
    logic            push, full, q_valid, q_pop;
    pfe_pkg::t_entry f_entry, q_entry;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_a <= '0;
            r_bound_b <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pfe_pkg::CFG_BOUND_A: r_bound_a <= i_cfg_data;
                pfe_pkg::CFG_BOUND_B: r_bound_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_char_code(i_char_code),
        .i_last_char(i_last_char),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (f_entry)
    );

    pfe_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(f_entry),
        .o_full (full),
        .o_valid(q_valid),
        .o_entry(q_entry),
        .i_pop  (q_pop)
    );

    pfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .i_bound_a   (r_bound_a),
        .i_bound_b   (r_bound_b),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_min_result(o_min_result),
        .o_max_result(o_max_result),
        .o_status    (o_status)
    );
endmodule
`default_nettype wire

// ===== rtl/pfe_checker.sv =====
// Port-level checks of the postfix range evaluator and their bind.
// Depends on pfe_pkg; attaches to postfix_expression_range_min_max.
`default_nettype none
module pfe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [7:0]  i_char_code,
    input wire logic        i_last_char,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_min_result,
    input wire logic [31:0] o_max_result,
    input wire logic [2:0]  o_status,
    input wire logic        i_cfg_valid,
    input wire logic        o_cfg_ready,
    input wire logic        i_cfg_index,
    input wire logic [31:0] i_cfg_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_min_result)
            && $stable(o_max_result) && $stable(o_status))
        else $error("result beat changed while stalled");

    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != pfe_pkg::ST_OK |->
            o_min_result == pfe_pkg::S32_MAX && o_max_result == pfe_pkg::S32_MIN)
        else $error("error result carries values");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == pfe_pkg::ST_OK |->
            $signed(o_min_result) <= $signed(o_max_result)
            || (o_min_result == pfe_pkg::S32_MAX && o_max_result == pfe_pkg::S32_MIN))
        else $error("minimum above maximum");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= pfe_pkg::ST_STACK)
        else $error("status code out of range");
endmodule

bind postfix_expression_range_min_max pfe_checker u_pfe_checker (.*);
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the postfix range evaluator (min/max over an x interval).
// Depends on pfe_pkg and postfix_expression_range_min_max from the rtl folder.
`timescale 1ns / 100ps

typedef struct {
    logic [31:0] min_val;
    logic [31:0] max_val;
    logic [2:0]  status;
} t_range_result;

class range_scoreboard;
    logic [31:0]     bound_a = '0;
    logic [31:0]     bound_b = '0;
    pfe_pkg::t_token prog[pfe_pkg::PROGRAM_DEPTH];
    int unsigned     prog_len = 0;
    logic [31:0]     lit_accum = '0;
    bit              lit_open = 0;
    logic [2:0]      load_err = pfe_pkg::ST_OK;
    t_range_result   pending[$];
    int              mismatches = 0;
    int              results_seen = 0;
    int              chars_seen = 0;

    function void set_bound(logic idx, logic [31:0] data);
        if (idx == pfe_pkg::CFG_BOUND_A) bound_a = data;
        else bound_b = data;
    endfunction

    function void flag_error(logic [2:0] code);
        if (load_err == pfe_pkg::ST_OK) load_err = code;
    endfunction

    function void push_token(pfe_pkg::t_kind kind, logic [31:0] value);
        if (prog_len >= pfe_pkg::PROGRAM_DEPTH) begin
            flag_error(pfe_pkg::ST_LONG);
            return;
        end
        prog[prog_len].kind = kind;
        prog[prog_len].value = value;
        prog_len++;
    endfunction

    function void close_literal();
        if (lit_open && lit_accum <= pfe_pkg::S32_MAX) push_token(pfe_pkg::TK_NUM, lit_accum);
        lit_open = 0;
        lit_accum = '0;
    endfunction

    function logic [2:0] shape_status();
        int depth;
        depth = 0;
        if (prog_len == 0) return pfe_pkg::ST_MALFORMED;
        for (int i = 0; i < prog_len; i++) begin
            if (prog[i].kind == pfe_pkg::TK_NUM || prog[i].kind == pfe_pkg::TK_VAR) begin
                if (depth >= pfe_pkg::STACK_DEPTH) return pfe_pkg::ST_STACK;
                depth++;
            end else begin
                if (depth < 2) return pfe_pkg::ST_MALFORMED;
                depth--;
            end
        end
        return pfe_pkg::ST_OK;
    endfunction

    // Returns 0 when this x divides by zero.
    function bit eval_at(logic [31:0] x, output logic [31:0] res);
        logic [31:0] stk[pfe_pkg::STACK_DEPTH];
        int          sp;
        logic [31:0] l, r, v;
        longint      q;
        sp = 0;
        res = '0;
        for (int i = 0; i < prog_len; i++) begin
            if (prog[i].kind == pfe_pkg::TK_NUM || prog[i].kind == pfe_pkg::TK_VAR) begin
                stk[sp] = (prog[i].kind == pfe_pkg::TK_NUM) ? prog[i].value : x;
                sp++;
            end else begin
                r = stk[sp-1];
                l = stk[sp-2];
                case (prog[i].kind)
                    pfe_pkg::TK_ADD: v = l + r;
                    pfe_pkg::TK_SUB: v = l - r;
                    pfe_pkg::TK_MUL: v = l * r;
                    default: begin
                        if (r == 0) return 0;
                        q = longint'($signed(l)) / longint'($signed(r));
                        v = q[31:0];
                    end
                endcase
                sp--;
                stk[sp-1] = v;
            end
        end
        res = stk[sp-1];
        return 1;
    endfunction

    function void note_char(logic [7:0] c, logic last);
        longint        nxt;
        t_range_result exp_res;
        longint        lo, hi;
        logic [31:0]   v;
        chars_seen++;
        if (c >= pfe_pkg::CH_ZERO && c <= pfe_pkg::CH_NINE) begin
            nxt = longint'(lit_accum) * 10 + (c - pfe_pkg::CH_ZERO);
            if (nxt > longint'(pfe_pkg::S32_MAX)) begin
                flag_error(pfe_pkg::ST_LITERAL);
                nxt = longint'(pfe_pkg::S32_MAX) + 1;
            end
            lit_accum = nxt[31:0];
            lit_open = 1;
        end else begin
            close_literal();
            case (c)
                pfe_pkg::CH_PLUS:  push_token(pfe_pkg::TK_ADD, '0);
                pfe_pkg::CH_MINUS: push_token(pfe_pkg::TK_SUB, '0);
                pfe_pkg::CH_STAR:  push_token(pfe_pkg::TK_MUL, '0);
                pfe_pkg::CH_SLASH: push_token(pfe_pkg::TK_DIV, '0);
                pfe_pkg::CH_X:     push_token(pfe_pkg::TK_VAR, '0);
                default: ;
            endcase
        end
        if (!last) return;
        close_literal();
        exp_res.status = (load_err != pfe_pkg::ST_OK) ? load_err : shape_status();
        exp_res.min_val = pfe_pkg::S32_MAX;
        exp_res.max_val = pfe_pkg::S32_MIN;
        if (exp_res.status == pfe_pkg::ST_OK) begin
            lo = longint'($signed(bound_a));
            hi = longint'($signed(bound_b));
            if (lo > hi) begin
                nxt = lo; lo = hi; hi = nxt;
            end
            for (longint x = lo; x <= hi; x++) begin
                if (!eval_at(x[31:0], v)) continue;
                if ($signed(v) < $signed(exp_res.min_val)) exp_res.min_val = v;
                if ($signed(v) > $signed(exp_res.max_val)) exp_res.max_val = v;
            end
        end
        pending.push_back(exp_res);
        prog_len = 0;
        lit_accum = '0;
        lit_open = 0;
        load_err = pfe_pkg::ST_OK;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("MISMATCH result %0d %s: got %h, expected %h", results_seen, what, got, want);
    endtask

    task check(logic [31:0] min_val, logic [31:0] max_val, logic [2:0] status);
        t_range_result e;
        results_seen++;
        if (pending.size() == 0) begin
            report("unexpected beat", {29'd0, status}, '0);
            return;
        end
        e = pending.pop_front();
        if (status !== e.status) report("status", {29'd0, status}, {29'd0, e.status});
        if (min_val !== e.min_val) report("min", min_val, e.min_val);
        if (max_val !== e.max_val) report("max", max_val, e.max_val);
    endtask
endclass

module testbench;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE = 40;
    localparam int PHASE_CHARS = 90;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [7:0]  i_char_code = '0;
    logic        i_last_char = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [31:0] o_min_result;
    logic [31:0] o_max_result;
    logic [2:0]  o_status;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic        i_cfg_index = pfe_pkg::CFG_BOUND_A;
    logic [31:0] i_cfg_data = '0;

    range_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  cycles = 0;
    byte unsigned expr_chars[$];

    postfix_expression_range_min_max u_top (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall) sb.check(o_min_result, o_max_result, o_status);

    task send_char(byte unsigned c, logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_char_code <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_char(c, last);
    endtask

    task play_expr();
        for (int i = 0; i < expr_chars.size(); i++)
            send_char(expr_chars[i], i == expr_chars.size() - 1);
        expr_chars.delete();
    endtask

    task play_text(string s);
        for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
        play_expr();
    endtask

    task wait_drained();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_bounds(logic [31:0] a, logic [31:0] b);
        wait_drained();
        for (int k = 0; k < 2; k++) begin
            i_cfg_valid <= 1;
            i_cfg_index <= (k == 0) ? pfe_pkg::CFG_BOUND_A : pfe_pkg::CFG_BOUND_B;
            i_cfg_data <= (k == 0) ? a : b;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_bound(i_cfg_index, i_cfg_data);
        end
        i_cfg_valid <= 0;
    endtask

    function byte unsigned pick_separator();
        byte unsigned c;
        do c = $urandom_range(0, 255);
        while ((c >= pfe_pkg::CH_ZERO && c <= pfe_pkg::CH_NINE) || c == pfe_pkg::CH_PLUS ||
               c == pfe_pkg::CH_MINUS || c == pfe_pkg::CH_STAR || c == pfe_pkg::CH_SLASH ||
               c == pfe_pkg::CH_X);
        return c;
    endfunction

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
    endfunction

    // Builds a postfix expression; a broken one may underflow or leave operands.
    function void build_expr(int max_tokens, bit broken);
        int    depth, n;
        int    roll;
        byte unsigned ops[4];
        longint lit;
        ops = '{pfe_pkg::CH_PLUS, pfe_pkg::CH_MINUS, pfe_pkg::CH_STAR, pfe_pkg::CH_SLASH};
        depth = 0;
        n = 0;
        while (n < max_tokens) begin
            roll = $urandom_range(0, 99);
            if (depth >= 2 && (roll < 45 || depth >= 12) || broken && roll < 8) begin
                expr_chars.push_back(ops[$urandom_range(0, 3)]);
                depth = (depth > 0) ? depth - 1 : 0;
            end else if (roll < 75) begin
                expr_chars.push_back(pfe_pkg::CH_X);
                depth++;
            end else begin
                case ($urandom_range(0, 9))
                    0: lit = $urandom_range(0, 32'h7FFF_FFFF);
                    1: lit = longint'(pfe_pkg::S32_MAX) + $urandom_range(0, 1) * $urandom;
                    2: lit = 32'h7FFF_FFFF;
                    default: lit = $urandom_range(0, 20);
                endcase
                if ($urandom_range(0, 7) == 0) expr_chars.push_back(pfe_pkg::CH_ZERO);
                add_text($sformatf("%0d", lit));
                expr_chars.push_back(pick_separator());
                depth++;
            end
            if ($urandom_range(0, 1)) expr_chars.push_back(pick_separator());
            n++;
        end
        if (!broken)
            while (depth > 1) begin
                expr_chars.push_back(ops[$urandom_range(0, 3)]);
                depth--;
            end
        if (depth == 0 && !broken) expr_chars.push_back(pfe_pkg::CH_X);
        if ($urandom_range(0, 3) == 0) expr_chars.push_back(pick_separator());
    endfunction

    task random_phase(int n_chars, logic [31:0] a, logic [31:0] b);
        int start;
        write_bounds(a, b);
        start = sb.chars_seen;
        while (sb.chars_seen - start < n_chars) begin
            case ($urandom_range(0, 19))
                0: begin
                    repeat ($urandom_range(1, 8)) expr_chars.push_back($urandom_range(0, 255));
                end
                1, 2: build_expr($urandom_range(1, 10), 1);
                default: build_expr($urandom_range(1, 14), 0);
            endcase
            play_expr();
        end
    endtask

    // A random base that leaves room for a short interval above it without signed wrap.
    function logic [31:0] pick_base();
        logic [31:0] b;
        b = $urandom;
        if ($signed(b) > $signed(32'h7FFF_FFF0)) b = b - 32'd16;
        return b;
    endfunction

    initial begin
        logic [31:0] base;
        string s;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Bounds at reset value: x is zero only.
        play_text("x 3 +");
        write_bounds(32'd3, -32'sd2);
        play_text(" ");
        play_text("x");
        play_text("12");
        play_text("2147483647 x +");
        play_text("2147483648 x");
        play_text("99999999999");
        play_text("+");
        play_text("x +");
        play_text("1 x /");
        play_text("0 2147483647 - 1 - 0 1 - /");
        play_text("1 2 x");
        play_text("x 7 * 3 - x x * -");
        s = "";
        for (int i = 0; i < 33; i++) s = {s, "x "};
        play_text(s);
        s = "";
        for (int i = 0; i < 65; i++) s = {s, "1 "};
        play_text(s);
        s = "";
        for (int i = 0; i < 32; i++) s = {s, "x "};
        for (int i = 0; i < 31; i++) s = {s, "+"};
        play_text(s);
        play_text("5 5555555555 +");
        play_text("x x x x x x x x x x - - - - - - - - - x / 255");

        send_idle_pct = 18;
        recv_idle_pct = 75;
        random_phase(PHASE_CHARS, 32'h7FFF_FFFF, 32'h7FFF_FFFC);
        random_phase(PHASE_CHARS, 32'h8000_0000, 32'h8000_0003);
        random_phase(PHASE_CHARS, 32'd4, -32'sd4);
        send_idle_pct = 75;
        recv_idle_pct = 18;
        base = pick_base();
        random_phase(PHASE_CHARS, base, base + $urandom_range(0, 6));
        random_phase(PHASE_CHARS, 32'h8000_0000, 32'h8000_0000);
        random_phase(PHASE_CHARS, -32'sd3, 32'd2);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        base = pick_base();
        random_phase(PHASE_CHARS, base + 5, base);
        random_phase(PHASE_CHARS, 32'hFFFF_FFFF, 32'd1);
        random_phase(PHASE_CHARS, 32'd0, 32'd0);

        wait_drained();
        $display("Checked %0d results from %0d characters: directed cases, then nine",
                 sb.results_seen, sb.chars_seen);
        $display("random phases with varied bounds and sender and receiver idling.");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
